// ----- hdl/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and codes for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_REPORT  = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_ANSWER = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic REG_FIT_MODE   = 1'b0;
    localparam logic REG_SLOT_COUNT = 1'b1;

    localparam int AMOUNT_BITS = 16;

    typedef struct packed {
        t_action    action;
        logic [3:0] slot_index;
        logic [15:0] amount;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic        granted;
        logic [3:0]  slot;
        logic [15:0] slot_size;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ_SCAN,
        ST_REQ_DRAIN,
        ST_REQ_ANS,
        ST_REP_RD,
        ST_REP_CHK,
        ST_REP_END
    } t_state;

endpackage

// ----- hdl/ffa_cmp.sv -----
// ----------------------------------------------------------------------------
// ffa_cmp
// Fit compare unit: decides whether one candidate slot replaces the
// current pick under the selected placement policy.
// ----------------------------------------------------------------------------
module ffa_cmp import ffa_pkg::*; #(
    parameter int SIZE_BITS = 16
) (
    input  logic [1:0]             i_mode,
    input  logic [SIZE_BITS-1:0]   i_cand,
    input  logic [SIZE_BITS-1:0]   i_best,
    input  logic                   i_have,
    input  logic [AMOUNT_BITS-1:0] i_amount,
    output logic                   o_take
);

    localparam int CW = (SIZE_BITS > AMOUNT_BITS) ? SIZE_BITS : AMOUNT_BITS;

    logic [CW-1:0] cand_w;
    logic [CW-1:0] amt_w;
    logic          fits;
    logic          better;

    assign cand_w = CW'(i_cand);
    assign amt_w  = CW'(i_amount);
    assign fits   = (cand_w >= amt_w);

    // ties keep the earlier (lower) index
    always_comb begin
        case (i_mode)
            FIT_FIRST: better = !i_have;
            FIT_BEST:  better = !i_have || (i_cand < i_best);
            FIT_WORST: better = !i_have || (i_cand > i_best);
            default:   better = !i_have;
        endcase
    end

    assign o_take = fits && better;

endmodule

// ----- hdl/fixed_partition_fit_allocator_core.sv -----
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Partition table with first / best / worst fit allocation and free-slot
// listing; requests are scanned one slot per cycle through the compare unit.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------
//  input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
//  output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//  config    | psel, penable, pwrite      | paddr, pwdata, prdata, pready
//
//  load and unknown items finish in the accept cycle
//  request: scan n = min(slot_count, SLOTS) slots, drain, answer (answer only
//  if n is 0); one slot per cycle via size memory read port and compare unit
//  report: accept, a read and a check state per slot, then the closing item
//  reset clears used marks, registers and control; sizes are undefined
//  until loaded; a stalled output holds the answer or the report scan
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core import ffa_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state                r_state;
    t_state                n_state;
    logic [1:0]            r_fit_mode;
    logic [4:0]            r_slot_count;
    logic [SIZE_BITS-1:0]  r_mem [SLOTS];
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic [SLOTS-1:0]      r_used;
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_last_idx;
    logic [AMOUNT_BITS-1:0] r_amount;
    logic                  r_chk_vld;
    logic [AW-1:0]         r_chk_idx;
    logic                  r_have;
    logic [AW-1:0]         r_best_idx;
    logic [SIZE_BITS-1:0]  r_best_size;
    logic                  r_hold_vld;
    logic [AW-1:0]         r_hold_idx;
    logic [SIZE_BITS-1:0]  r_hold_size;
    logic                  r_out_vld;
    t_out_item             r_out;

    logic                  in_fire;
    logic                  cfg_we;
    logic                  load_we;
    logic [AW-1:0]         wr_addr;
    logic                  zero_c;
    logic [AW-1:0]         last_idx_c;
    logic                  idx_at_last;
    logic                  out_free;
    logic                  cmp_take;
    logic                  chk_take;
    logic                  rep_free;
    logic                  rep_go;
    logic                  out_load;
    t_out_item             out_data;
    logic                  hold_load;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_FIT_MODE:   prdata = {30'd0, r_fit_mode};
            REG_SLOT_COUNT: prdata = {27'd0, r_slot_count};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- handshake and decode ----------------
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;
    assign out_free    = !r_out_vld || i_out_ready;

    assign wr_addr = AW'(i_in_item.slot_index);
    assign load_we = in_fire && (i_in_item.action == ACT_LOAD)
                     && (32'(i_in_item.slot_index) < SLOTS);

    // slot counts above the table size act as the table size
    assign zero_c     = (r_slot_count == 5'd0);
    assign last_idx_c = (32'(r_slot_count) >= SLOTS) ? AW'(SLOTS - 1)
                                                     : AW'(32'(r_slot_count) - 32'd1);
    assign idx_at_last = (r_idx == r_last_idx);

    ffa_cmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cmp (
        .i_mode   (r_fit_mode),
        .i_cand   (r_rd_data),
        .i_best   (r_best_size),
        .i_have   (r_have),
        .i_amount (r_amount),
        .o_take   (cmp_take)
    );

    assign chk_take = r_chk_vld && !r_used[r_chk_idx] && cmp_take;
    assign rep_free = !r_used[r_idx];
    // a free slot may only replace the held one once the held one can leave
    assign rep_go   = !rep_free || !r_hold_vld || out_free;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in_item.action)
                        ACT_REQUEST: n_state = zero_c ? ST_REQ_ANS : ST_REQ_SCAN;
                        ACT_REPORT:  n_state = zero_c ? ST_REP_END : ST_REP_RD;
                        default:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_REQ_SCAN: begin
                if (idx_at_last) begin
                    n_state = ST_REQ_DRAIN;
                end
            end
            ST_REQ_DRAIN: n_state = ST_REQ_ANS;
            ST_REQ_ANS: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_REP_RD: n_state = ST_REP_CHK;
            ST_REP_CHK: begin
                if (rep_go) begin
                    n_state = idx_at_last ? ST_REP_END : ST_REP_RD;
                end
            end
            ST_REP_END: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb begin
        out_load  = 1'b0;
        hold_load = 1'b0;
        out_data  = '0;
        case (r_state)
            ST_REQ_ANS: begin
                out_load       = out_free;
                out_data.kind  = KIND_ANSWER;
                out_data.last  = 1'b1;
                if (r_have) begin
                    out_data.granted   = 1'b1;
                    out_data.slot      = 4'(r_best_idx);
                    out_data.slot_size = 16'(r_best_size);
                end
            end
            ST_REP_CHK: begin
                out_data.kind      = KIND_FREE;
                out_data.slot      = 4'(r_hold_idx);
                out_data.slot_size = 16'(r_hold_size);
                if (rep_free && rep_go) begin
                    hold_load = 1'b1;
                    out_load  = r_hold_vld;
                end
            end
            ST_REP_END: begin
                out_load      = out_free;
                out_data.last = 1'b1;
                if (r_hold_vld) begin
                    out_data.kind      = KIND_FREE;
                    out_data.slot      = 4'(r_hold_idx);
                    out_data.slot_size = 16'(r_hold_size);
                end else begin
                    out_data.kind = KIND_EMPTY;
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fit_mode   <= FIT_FIRST;
            r_slot_count <= 5'd0;
            r_used       <= '0;
            r_out_vld    <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_have       <= 1'b0;
            r_hold_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == ST_REQ_SCAN);

            if (cfg_we) begin
                case (paddr[2])
                    REG_FIT_MODE:   r_fit_mode   <= pwdata[1:0];
                    REG_SLOT_COUNT: r_slot_count <= pwdata[4:0];
                    default:        r_fit_mode   <= r_fit_mode;
                endcase
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            if (load_we) begin
                r_used[wr_addr] <= 1'b0;
            end else if ((r_state == ST_REQ_ANS) && out_free && r_have) begin
                r_used[r_best_idx] <= 1'b1;
            end

            if (in_fire) begin
                r_have <= 1'b0;
            end else if (chk_take) begin
                r_have <= 1'b1;
            end

            if (in_fire) begin
                r_hold_vld <= 1'b0;
            end else if (hold_load) begin
                r_hold_vld <= 1'b1;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end

        if (in_fire) begin
            r_idx      <= '0;
            r_last_idx <= last_idx_c;
            r_amount   <= i_in_item.amount;
        end else if ((r_state == ST_REQ_SCAN) && !idx_at_last) begin
            r_idx <= r_idx + 1'b1;
        end else if ((r_state == ST_REP_CHK) && rep_go && !idx_at_last) begin
            r_idx <= r_idx + 1'b1;
        end

        r_chk_idx <= r_idx;

        if (chk_take) begin
            r_best_idx  <= r_chk_idx;
            r_best_size <= r_rd_data;
        end

        if (hold_load) begin
            r_hold_idx  <= r_idx;
            r_hold_size <= r_rd_data;
        end
    end

    // size memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_mem[wr_addr] <= SIZE_BITS'(i_in_item.amount);
        end
        r_rd_data <= r_mem[r_idx];
    end

endmodule

// ----- hdl/ffa_checker.sv -----
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
module ffa_checker import ffa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a stalled result item stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // requests and reports drop ready in the cycle after they are accepted
    a_busy_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready
        && (i_in_item.action == ACT_REQUEST || i_in_item.action == ACT_REPORT)
        |=> !o_in_ready)
        else $error("ready did not drop after a scanning item");

    // a grant is only ever carried by a request answer
    a_grant_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.granted |-> o_out_item.kind == KIND_ANSWER)
        else $error("grant on a report item");

    // answers and empty reports close their item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == KIND_ANSWER || o_out_item.kind == KIND_EMPTY)
        |-> o_out_item.last && (o_out_item.kind == KIND_ANSWER || !o_out_item.granted))
        else $error("single result item without last");

endmodule

bind fixed_partition_fit_allocator_core ffa_checker u_ffa_checker (.*);

// ----- test/fixed_partition_fit_allocator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core_test
// Drives load, request, report and unknown items into the partition allocator
// under first, best and worst fit and several slot counts. A local copy of the
// partition table predicts every answer and free-slot listing, and a monitor
// checks each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core_test import ffa_pkg::*;;

    localparam int SLOTS         = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;

    // fit mode value the block treats as first fit
    localparam logic [1:0] FIT_UNUSED = 2'd3;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item  = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    always #5 i_clk = ~i_clk;

    fixed_partition_fit_allocator_core #(
        .SLOTS     (SLOTS),
        .SIZE_BITS (16)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // local copy of the partition table and registers
    logic [15:0] part_size [SLOTS];
    bit          part_used [SLOTS];
    logic [1:0]  fit_policy = FIT_FIRST;
    logic [4:0]  slot_limit = '0;
    t_out_item   awaited_results [$];

    typedef struct packed {
        logic     hold;
        t_in_item item;
    } t_queued_item;

    t_queued_item pending_items [$];
    int unsigned  queued_count   = 0;
    int unsigned  accepted_count = 0;
    int           send_idle_pct  = 0;
    int           recv_idle_pct  = 0;
    int           mismatch_count = 0;

    logic [15:0] seed_sizes [SLOTS] = '{
        16'd100, 16'd0, 16'd65535, 16'd300, 16'd100, 16'd50, 16'd300, 16'd1,
        16'd4000, 16'd50, 16'd65535, 16'd7, 16'd300, 16'd2, 16'd100, 16'd9
    };

    task automatic predict_partition_action(input t_in_item it);
        int        n;
        int        pick;
        int        last_free;
        bit        found;
        t_out_item r;
        n         = (slot_limit > SLOTS) ? SLOTS : int'(slot_limit);
        pick      = 0;
        last_free = -1;
        found     = 1'b0;
        r         = '0;
        case (it.action)
            ACT_LOAD: begin
                part_size[it.slot_index] = it.amount;
                part_used[it.slot_index] = 1'b0;
            end
            ACT_REQUEST: begin
                for (int i = 0; i < n; i++) begin
                    if (!part_used[i] && part_size[i] >= it.amount) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = i;
                        end else if (fit_policy == FIT_BEST && part_size[i] < part_size[pick]) begin
                            pick = i;
                        end else if (fit_policy == FIT_WORST && part_size[i] > part_size[pick]) begin
                            pick = i;
                        end
                    end
                end
                r.kind = KIND_ANSWER;
                r.last = 1'b1;
                if (found) begin
                    part_used[pick] = 1'b1;
                    r.granted       = 1'b1;
                    r.slot          = 4'(pick);
                    r.slot_size     = part_size[pick];
                end
                awaited_results.push_back(r);
            end
            ACT_REPORT: begin
                for (int i = 0; i < n; i++) begin
                    if (!part_used[i]) last_free = i;
                end
                if (last_free < 0) begin
                    r.kind = KIND_EMPTY;
                    r.last = 1'b1;
                    awaited_results.push_back(r);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        if (!part_used[i]) begin
                            r.kind      = KIND_FREE;
                            r.slot      = 4'(i);
                            r.slot_size = part_size[i];
                            r.last      = (i == last_free);
                            awaited_results.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // sender: presents queued items, with random gaps and drain pauses
    int   send_gap       = 0;
    logic hold_for_drain = 1'b0;

    always @(posedge i_clk) begin : sender
        t_queued_item next;
        logic         present;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            present = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                predict_partition_action(i_in_item);
                accepted_count++;
                present = 1'b0;
                if ($urandom_range(99, 0) < send_idle_pct) send_gap = $urandom_range(14, 1);
            end
            if (!present && send_gap > 0) begin
                send_gap--;
            end else if (!present && hold_for_drain) begin
                hold_for_drain = (awaited_results.size() != 0);
            end else if (!present && pending_items.size() != 0) begin
                next = pending_items.pop_front();
                if (next.hold) begin
                    hold_for_drain = 1'b1;
                end else begin
                    i_in_item <= next.item;
                    present   = 1'b1;
                end
            end
            i_in_valid <= present;
        end
    end

    // receiver: random stall bursts
    int recv_stall = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(99, 0) < recv_idle_pct) begin
            recv_stall = $urandom_range(13, 0);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: expected no result, got kind %0d slot %0d size %0d", $time,
                         o_out_item.kind, o_out_item.slot, o_out_item.slot_size);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("kind", want.kind, o_out_item.kind);
                check_field("granted", want.granted, o_out_item.granted);
                check_field("slot", want.slot, o_out_item.slot);
                check_field("slot_size", want.slot_size, o_out_item.slot_size);
                check_field("last", want.last, o_out_item.last);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_item(input t_action act, input logic [3:0] idx,
                              input logic [15:0] amt);
        t_queued_item q;
        q.hold            = 1'b0;
        q.item.action     = act;
        q.item.slot_index = idx;
        q.item.amount     = amt;
        pending_items.push_back(q);
        queued_count++;
    endtask

    task automatic queue_hold();
        t_queued_item q;
        q      = '0;
        q.hold = 1'b1;
        pending_items.push_back(q);
    endtask

    task automatic settle();
        while (accepted_count != queued_count || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic reg_sel, input logic [31:0] value);
        settle();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_FIT_MODE) fit_policy = value[1:0];
        else slot_limit = value[4:0];
    endtask

    task automatic set_pressure(input int level);
        send_idle_pct = level * 25;
        recv_idle_pct = level * 6;
    endtask

    task automatic queue_random_items(input int count);
        int          made;
        int          roll;
        logic [15:0] amt;
        made = 0;
        while (made < count) begin
            roll = $urandom_range(99, 0);
            if (roll < 30) begin
                roll = $urandom_range(99, 0);
                if (roll < 50) amt = 16'(16 * $urandom_range(64, 1));
                else if (roll < 75) amt = 16'($urandom_range(1023, 0));
                else amt = 16'($urandom_range(65535, 0));
                queue_item(ACT_LOAD, 4'($urandom_range(15, 0)), amt);
                made++;
            end else if (roll < 80) begin
                roll = $urandom_range(99, 0);
                if (roll < 70) amt = 16'($urandom_range(600, 0));
                else if (roll < 85) amt = '0;
                else amt = 16'($urandom_range(65535, 0));
                queue_item(ACT_REQUEST, 4'($urandom_range(15, 0)), amt);
                made++;
            end else if (roll < 93) begin
                queue_item(ACT_REPORT, 4'($urandom_range(15, 0)), 16'($urandom_range(65535, 0)));
                made++;
            end else begin
                queue_item(ACT_NONE, 4'($urandom_range(15, 0)), 16'($urandom_range(65535, 0)));
            end
            if ($urandom_range(39, 0) == 0) queue_hold();
        end
    endtask

    initial begin
        int roll;
        int count_value;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_pressure(1);

        // no slots in use yet: empty report and refused request
        queue_item(ACT_REPORT, 4'd0, 16'd0);
        queue_item(ACT_REQUEST, 4'd0, 16'd0);
        queue_item(ACT_NONE, 4'd15, 16'hffff);
        for (int i = 0; i < SLOTS; i++) queue_item(ACT_LOAD, 4'(i), seed_sizes[i]);

        set_register(REG_SLOT_COUNT, 32'd16);
        queue_item(ACT_REQUEST, 4'd0, 16'd200);
        queue_item(ACT_REPORT, 4'd0, 16'd0);
        queue_hold();
        set_register(REG_FIT_MODE, {30'd0, FIT_BEST});
        queue_item(ACT_REQUEST, 4'd0, 16'd100);
        queue_item(ACT_REQUEST, 4'd0, 16'hffff);
        set_register(REG_FIT_MODE, {30'd0, FIT_WORST});
        queue_item(ACT_REQUEST, 4'd0, 16'd1);
        set_register(REG_FIT_MODE, {30'd0, FIT_UNUSED});
        queue_item(ACT_REQUEST, 4'd0, 16'd0);
        // slot count beyond the table acts as the full table
        set_register(REG_SLOT_COUNT, 32'd31);
        queue_item(ACT_REPORT, 4'd0, 16'd0);
        set_register(REG_SLOT_COUNT, 32'd1);
        queue_item(ACT_REQUEST, 4'd0, 16'd0);
        queue_item(ACT_REPORT, 4'd0, 16'd0);

        for (int p = 0; p < 8; p++) begin
            roll = $urandom_range(99, 0);
            if (roll < 50) count_value = 16;
            else if (roll < 75) count_value = $urandom_range(15, 1);
            else if (roll < 90) count_value = $urandom_range(31, 17);
            else count_value = 0;
            set_register(REG_FIT_MODE, 32'($urandom_range(3, 0)));
            set_register(REG_SLOT_COUNT, 32'(count_value));
            set_pressure((p == 7) ? 0 : $urandom_range(2, 0));
            queue_random_items(20);
        end

        settle();
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
